// File: rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_PRE_LOW  = 2'd0;
    localparam logic [1:0] REG_PULSE    = 2'd1;
    localparam logic [1:0] REG_POST_LOW = 2'd2;
    localparam logic [1:0] REG_SCALE    = 2'd3;

    localparam logic [7:0]  PRE_LOW_RST  = 8'd20;
    localparam logic [7:0]  PULSE_RST    = 8'd12;
    localparam logic [7:0]  POST_LOW_RST = 8'd20;
    localparam logic [15:0] SCALE_RST    = 16'd1311;

    typedef struct packed {
        logic [7:0]  pre_low;
        logic [7:0]  pulse;
        logic [7:0]  post_low;
        logic [15:0] scale;
    } uer_cfg_t;

    typedef struct packed {
        logic busy;
        logic zero_div;
    } uer_div_stat_t;

endpackage

// File: rtl/ultrasonic_echo_ranger_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_top
// Ultrasonic echo ranger: triggers readings, times echo pulses, divides.
// ----------------------------------------------------------------------------
// Every input beat is one timebase tick and yields exactly one result beat.
// A tick that does not end a ranging has its result beat in the output
// register from the next cycle on; the input stalls while that register is
// still full and stalled. The tick that ends the last reading of a ranging
// starts the restoring divider, which produces one quotient bit per cycle:
// that tick's beat with the new distance enters the output register once
// the divider is done and that register is free, and no input is taken
// meanwhile. Configuration is reached at byte addresses 0, 4, 8, 12.
module ultrasonic_echo_ranger_top #(
    parameter int READINGS   = 3,
    parameter int COUNT_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [uer_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      start_req,
    input  logic                      echo,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      trigger,
    output logic                      busy_res,
    output logic                      done_res,
    output logic [31:0]               distance
);
    import uer_pkg::*;

    localparam int SUM_W = COUNT_BITS + $clog2(READINGS);
    localparam int DIV_W = 16 + $clog2(READINGS + 1);

    uer_cfg_t         cfg;
    uer_div_stat_t    div_stat;
    logic             div_start;
    logic [SUM_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [SUM_W-1:0] div_quotient;

    uer_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uer_div #(
        .SUM_W (SUM_W),
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    uer_ctrl #(
        .READINGS   (READINGS),
        .COUNT_BITS (COUNT_BITS),
        .SUM_W      (SUM_W),
        .DIV_W      (DIV_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_req    (start_req),
        .echo         (echo),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .trigger      (trigger),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .distance     (distance),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_stat     (div_stat),
        .div_quotient (div_quotient)
    );

endmodule

// File: rtl/uer_regs.sv
// ----------------------------------------------------------------------------
// uer_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module uer_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [uer_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output uer_pkg::uer_cfg_t         cfg
);
    import uer_pkg::*;

    uer_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pre_low  <= PRE_LOW_RST;
            cfg_reg.pulse    <= PULSE_RST;
            cfg_reg.post_low <= POST_LOW_RST;
            cfg_reg.scale    <= SCALE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PRE_LOW:  cfg_reg.pre_low  <= pwdata[7:0];
                REG_PULSE:    cfg_reg.pulse    <= pwdata[7:0];
                REG_POST_LOW: cfg_reg.post_low <= pwdata[7:0];
                REG_SCALE:    cfg_reg.scale    <= pwdata[15:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PRE_LOW:  prdata = 32'(cfg_reg.pre_low);
            REG_PULSE:    prdata = 32'(cfg_reg.pulse);
            REG_POST_LOW: prdata = 32'(cfg_reg.post_low);
            REG_SCALE:    prdata = 32'(cfg_reg.scale);
            default:      prdata = '0;
        endcase
    end

endmodule

// File: rtl/uer_div.sv
// ----------------------------------------------------------------------------
// uer_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module uer_div #(
    parameter int SUM_W = 34,
    parameter int DIV_W = 18
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SUM_W-1:0]       dividend,
    input  logic [DIV_W-1:0]       divisor,
    output logic [SUM_W-1:0]       quotient,
    output uer_pkg::uer_div_stat_t stat
);
    import uer_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [DIV_W-1:0] rem_reg;
    logic [SUM_W-1:0] quo_reg;
    logic [DIV_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             zero_reg;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    assign quotient      = quo_reg;
    assign stat.busy     = busy_reg;
    assign stat.zero_div = zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dsr_reg  <= divisor;
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

endmodule

// File: rtl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Tick sequencer: trigger phases, echo counting, result beat register.
// ----------------------------------------------------------------------------
module uer_ctrl #(
    parameter int READINGS   = 3,
    parameter int COUNT_BITS = 32,
    parameter int SUM_W      = 34,
    parameter int DIV_W      = 18
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  uer_pkg::uer_cfg_t      cfg,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   start_req,
    input  logic                   echo,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   trigger,
    output logic                   busy_res,
    output logic                   done_res,
    output logic [31:0]            distance,
    output logic                   div_start,
    output logic [SUM_W-1:0]       div_dividend,
    output logic [DIV_W-1:0]       div_divisor,
    input  uer_pkg::uer_div_stat_t div_stat,
    input  logic [SUM_W-1:0]       div_quotient
);
    import uer_pkg::*;

    localparam int IDX_W = $clog2(READINGS + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_PRE    = 5'b00010,
        PH_PULSE  = 5'b00100,
        PH_POST   = 5'b01000,
        PH_LISTEN = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        SQ_TICK = 2'b01,
        SQ_DIV  = 2'b10
    } seq_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        ticks_reg, ticks_next;
    logic [COUNT_BITS-1:0] echo_cnt_reg, echo_cnt_next;
    logic              seen_reg, seen_next;
    logic              prev_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [31:0]       dist_reg, dist_next;
    seq_t              seq_reg, seq_next;
    logic              out_valid_reg, out_valid_next;
    logic              trigger_reg, busy_reg, done_reg;

    logic              accept;
    logic              out_free;
    logic              finish;
    logic              tick_done;

    function automatic phase_t skip_phase(phase_t p, uer_cfg_t c);
        phase_t r;
        r = p;
        if (r == PH_PRE && c.pre_low == 8'd0)
        begin
            r = PH_PULSE;
        end
        if (r == PH_PULSE && c.pulse == 8'd0)
        begin
            r = PH_POST;
        end
        if (r == PH_POST && c.post_low == 8'd0)
        begin
            r = PH_LISTEN;
        end
        return r;
    endfunction

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (seq_reg != SQ_TICK) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign finish   = (seq_reg == SQ_DIV) && !div_stat.busy && out_free;

    assign out_valid = out_valid_reg;
    assign trigger   = trigger_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign distance  = dist_reg;

    assign div_start    = accept && tick_done;
    assign div_dividend = sum_next;
    assign div_divisor  = DIV_W'(cfg.scale) * DIV_W'(READINGS);

    always_comb
    begin
        logic                  rising;
        logic                  falling;
        logic                  seen_new;
        logic [COUNT_BITS-1:0] cnt_base;
        logic [IDX_W-1:0]      idx_inc;
        logic [7:0]            inc;
        logic [7:0]            len;
        phase_t                after;

        phase_next    = phase_reg;
        ticks_next    = ticks_reg;
        echo_cnt_next = echo_cnt_reg;
        seen_next     = seen_reg;
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        tick_done     = 1'b0;

        rising   = echo && !prev_reg;
        falling  = !echo && prev_reg;
        seen_new = seen_reg || rising;
        cnt_base = rising ? '0 : echo_cnt_reg;
        idx_inc  = idx_reg + 1'b1;
        inc      = ticks_reg + 8'd1;
        len      = cfg.post_low;
        after    = PH_LISTEN;

        unique case (phase_reg) inside
            PH_IDLE:
            begin
                if (start_req)
                begin
                    idx_next      = '0;
                    sum_next      = '0;
                    echo_cnt_next = '0;
                    seen_next     = 1'b0;
                    ticks_next    = 8'd0;
                    phase_next    = skip_phase(PH_PRE, cfg);
                end
            end
            PH_LISTEN:
            begin
                seen_next = seen_new;
                if (echo && seen_new && cnt_base != CNT_MAX)
                begin
                    echo_cnt_next = cnt_base + 1'b1;
                end
                else
                begin
                    echo_cnt_next = cnt_base;
                end
                if (falling && seen_reg)
                begin
                    sum_next = sum_reg + SUM_W'(echo_cnt_next);
                    idx_next = idx_inc;
                    if (idx_inc >= IDX_W'(READINGS))
                    begin
                        phase_next = PH_IDLE;
                        ticks_next = 8'd0;
                        seen_next  = 1'b0;
                        tick_done  = 1'b1;
                    end
                    else
                    begin
                        echo_cnt_next = '0;
                        seen_next     = 1'b0;
                        ticks_next    = 8'd0;
                        phase_next    = skip_phase(PH_PRE, cfg);
                    end
                end
            end
            PH_PRE, PH_PULSE, PH_POST:
            begin
                if (phase_reg == PH_PRE)
                begin
                    len   = cfg.pre_low;
                    after = PH_PULSE;
                end
                else if (phase_reg == PH_PULSE)
                begin
                    len   = cfg.pulse;
                    after = PH_POST;
                end
                if (inc >= len || inc == 8'd0)
                begin
                    ticks_next = 8'd0;
                    phase_next = skip_phase(after, cfg);
                end
                else
                begin
                    ticks_next = inc;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        seq_next       = seq_reg;
        out_valid_next = out_valid_reg;
        dist_next      = dist_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (tick_done)
            begin
                seq_next = SQ_DIV;
            end
            else
            begin
                out_valid_next = 1'b1;
            end
        end
        if (finish)
        begin
            seq_next       = SQ_TICK;
            out_valid_next = 1'b1;
            dist_next      = div_stat.zero_div ? '1 : 32'(div_quotient[COUNT_BITS-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            ticks_reg    <= 8'd0;
            echo_cnt_reg <= '0;
            seen_reg     <= 1'b0;
            prev_reg     <= 1'b0;
            idx_reg      <= '0;
            sum_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            ticks_reg    <= ticks_next;
            echo_cnt_reg <= echo_cnt_next;
            seen_reg     <= seen_next;
            prev_reg     <= echo;
            idx_reg      <= idx_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SQ_TICK;
            out_valid_reg <= 1'b0;
            dist_reg      <= '0;
        end
        else
        begin
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
            dist_reg      <= dist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trigger_reg <= (phase_next == PH_PULSE);
            busy_reg    <= (phase_next != PH_IDLE);
            done_reg    <= tick_done;
        end
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> !busy_reg)
        else $error("done beat reports busy");

    a_trigger_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && trigger_reg |-> busy_reg)
        else $error("trigger high while idle");

    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (seq_reg == SQ_DIV) && div_stat.busy && in_stall)
        else $error("divide not running after final reading");

    a_dist_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(dist_reg))
        else $error("distance changed under a stalled beat");

endmodule
